/* rtl/stack_or_queue_order_checker_top_macros.svh */
// Assertion macros for the stack/queue order checker.
// Used by modules that include this header; expects clk and arst_n in scope.
`ifndef STACK_OR_QUEUE_ORDER_CHECKER_TOP_MACROS_SVH
`define STACK_OR_QUEUE_ORDER_CHECKER_TOP_MACROS_SVH

// Same-cycle implication, off during reset.
`define SOQOC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off during reset.
`define SOQOC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/soqoc_pkg.sv */
// Shared types, constants and helpers for the stack/queue order checker.
// No dependencies; used by soqoc_ctrl and stack_or_queue_order_checker_top.
`timescale 1ns / 1ps

package soqoc_pkg;

	localparam int DEPTH   = 2048;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int COUNT_W = $clog2(DEPTH + 1);

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	typedef struct packed {
		logic                     cmd;
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} cmd_item_t;

	typedef struct packed {
		logic fifo_consistent;
		logic lifo_consistent;
		logic trace_error;
		logic trace_done;
	} res_item_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] wr_fifo_addr;
		logic [ADDR_W-1:0] wr_stack_addr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] rd_fifo_addr;
		logic [ADDR_W-1:0] rd_stack_addr;
	} mem_req_t;

	function automatic logic [ADDR_W-1:0] next_pos(input logic [ADDR_W-1:0] p);
		return (p == ADDR_W'(DEPTH - 1)) ? '0 : ADDR_W'(p + 1'b1);
	endfunction

endpackage

/* rtl/soqoc_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module soqoc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/soqoc_ctrl.sv */
// Sequencer for the order checker: positions, count, sticky flags, pop compare.
// Depends on soqoc_pkg and stack_or_queue_order_checker_top_macros.svh.
`timescale 1ns / 1ps
`include "stack_or_queue_order_checker_top_macros.svh"

module soqoc_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  soqoc_pkg::cmd_item_t          cmd_item,
	input  logic                          out_free,
	output logic                          res_valid,
	output soqoc_pkg::res_item_t          res,
	output soqoc_pkg::mem_req_t           mem_req,
	input  logic [soqoc_pkg::DATA_W-1:0]  fifo_rdata,
	input  logic [soqoc_pkg::DATA_W-1:0]  stack_rdata
);

	logic [soqoc_pkg::ADDR_W-1:0]  head_q;
	logic [soqoc_pkg::ADDR_W-1:0]  tail_q;
	logic [soqoc_pkg::COUNT_W-1:0] count_q;
	logic [soqoc_pkg::COUNT_W-1:0] stack_top;
	logic                          fifo_ok_q;
	logic                          lifo_ok_q;
	logic                          err_q;

	logic                          valid_s1;
	logic [soqoc_pkg::DATA_W-1:0]  value_s1;
	logic                          last_s1;

	logic accept;
	logic is_pop;
	logic empty;
	logic full;
	logic do_push;
	logic do_read;
	logic fok_n;
	logic lok_n;
	logic err_n;
	logic done_n;

	assign cmd_stall = valid_s1 || !out_free;
	assign accept    = cmd_valid && !cmd_stall;
	assign is_pop    = (cmd_item.cmd == soqoc_pkg::CMD_POP);
	assign empty     = (count_q == '0);
	assign full      = (count_q == soqoc_pkg::COUNT_W'(soqoc_pkg::DEPTH));
	assign do_push   = accept && !is_pop && !full;
	assign do_read   = accept && is_pop && !empty;
	assign stack_top = count_q - soqoc_pkg::COUNT_W'(1);

	always_comb begin
		mem_req.we            = do_push;
		mem_req.wr_fifo_addr  = tail_q;
		mem_req.wr_stack_addr = count_q[soqoc_pkg::ADDR_W-1:0];
		mem_req.wdata         = cmd_item.value;
		mem_req.re            = do_read;
		mem_req.rd_fifo_addr  = head_q;
		mem_req.rd_stack_addr = stack_top[soqoc_pkg::ADDR_W-1:0];
	end

	// Result either finishes a pending pop or comes straight from the accepted item.
	always_comb begin
		fok_n     = fifo_ok_q;
		lok_n     = lifo_ok_q;
		err_n     = err_q;
		done_n    = cmd_item.last;
		res_valid = 1'b0;
		if (valid_s1) begin
			res_valid = out_free;
			done_n    = last_s1;
			fok_n     = fifo_ok_q && (fifo_rdata == value_s1);
			lok_n     = lifo_ok_q && (stack_rdata == value_s1);
		end else if (accept && !do_read) begin
			res_valid = 1'b1;
			if (is_pop) begin
				fok_n = 1'b0;
				lok_n = 1'b0;
				err_n = 1'b1;
			end else begin
				err_n = err_q || full;
			end
		end
	end

	always_comb begin
		res.fifo_consistent = fok_n;
		res.lifo_consistent = lok_n;
		res.trace_error     = err_n;
		res.trace_done      = done_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			fifo_ok_q <= 1'b1;
			lifo_ok_q <= 1'b1;
			err_q     <= 1'b0;
			valid_s1  <= 1'b0;
		end else begin
			if (do_push) begin
				tail_q  <= soqoc_pkg::next_pos(tail_q);
				count_q <= count_q + soqoc_pkg::COUNT_W'(1);
			end
			if (do_read) begin
				head_q   <= soqoc_pkg::next_pos(head_q);
				count_q  <= stack_top;
				valid_s1 <= 1'b1;
			end
			if (valid_s1 && out_free) begin
				valid_s1 <= 1'b0;
			end
			if (res_valid) begin
				fifo_ok_q <= fok_n;
				lifo_ok_q <= lok_n;
				err_q     <= err_n;
				// close the trace: drop everything after its last result
				if (done_n) begin
					head_q    <= '0;
					tail_q    <= '0;
					count_q   <= '0;
					fifo_ok_q <= 1'b1;
					lifo_ok_q <= 1'b1;
					err_q     <= 1'b0;
				end
			end
		end
	end

	// Hold the pop's observed value while the read is in flight.
	always_ff @(posedge clk) begin
		if (do_read) begin
			value_s1 <= cmd_item.value;
			last_s1  <= cmd_item.last;
		end
	end

	`SOQOC_ASSERT_NOW(a_count_range, 1'b1, count_q <= soqoc_pkg::COUNT_W'(soqoc_pkg::DEPTH), "entry count above depth")
	`SOQOC_ASSERT_NOW(a_no_write_on_read, mem_req.we, !mem_req.re, "write and read issued together")
	`SOQOC_ASSERT_NEXT(a_read_pends, do_read, valid_s1 && !accept, "pop read not pending next cycle")
	`SOQOC_ASSERT_NOW(a_res_room, res_valid, out_free, "result produced without output room")
	`SOQOC_ASSERT_NEXT(a_close_clears, res_valid && done_n, count_q == '0 && !err_q, "trace state not cleared")

endmodule

/* rtl/stack_or_queue_order_checker_top.sv */
// Push, or pop on an empty store: result valid in the cycle after accept.
// Pop with entries: registered RAM read, then compare, then output register.
// Throughput: 1 push item per cycle unless the output stalls; a reading pop holds input.
// Reset: arst_n clears positions, count, flags and valid bits; RAM is not cleared, so
// items are taken right after reset.
// Output register plus FIFO and stack RAMs; depends on soqoc_pkg, soqoc_ctrl, soqoc_ram.
`timescale 1ns / 1ps

module stack_or_queue_order_checker_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  soqoc_pkg::cmd_item_t cmd_item,
	output logic                 res_valid,
	input  logic                 res_stall,
	output soqoc_pkg::res_item_t res_item
);

	soqoc_pkg::mem_req_t          mem_req;
	soqoc_pkg::res_item_t         res_n;
	logic                         res_n_valid;
	logic                         out_free;
	logic                         out_valid_q;
	soqoc_pkg::res_item_t         out_q;
	logic [soqoc_pkg::DATA_W-1:0] fifo_rdata;
	logic [soqoc_pkg::DATA_W-1:0] stack_rdata;

	assign out_free  = !out_valid_q || !res_stall;
	assign res_valid = out_valid_q;
	assign res_item  = out_q;

	soqoc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd_item   (cmd_item),
		.out_free   (out_free),
		.res_valid  (res_n_valid),
		.res        (res_n),
		.mem_req    (mem_req),
		.fifo_rdata (fifo_rdata),
		.stack_rdata(stack_rdata)
	);

	soqoc_ram #(
		.WIDTH(soqoc_pkg::DATA_W),
		.DEPTH(soqoc_pkg::DEPTH)
	) u_fifo_ram (
		.clk  (clk),
		.we   (mem_req.we),
		.waddr(mem_req.wr_fifo_addr),
		.wdata(mem_req.wdata),
		.re   (mem_req.re),
		.raddr(mem_req.rd_fifo_addr),
		.rdata(fifo_rdata)
	);

	soqoc_ram #(
		.WIDTH(soqoc_pkg::DATA_W),
		.DEPTH(soqoc_pkg::DEPTH)
	) u_stack_ram (
		.clk  (clk),
		.we   (mem_req.we),
		.waddr(mem_req.wr_stack_addr),
		.wdata(mem_req.wdata),
		.re   (mem_req.re),
		.raddr(mem_req.rd_stack_addr),
		.rdata(stack_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res_n_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_n_valid) begin
			out_q <= res_n;
		end
	end

endmodule

/* sim/tb.sv */
// Testbench for stack_or_queue_order_checker_top: drives push/pop traces and checks every
// result against a predictor of the FIFO/LIFO consistency flags. Depends on soqoc_pkg.
`timescale 1ns / 1ps

module tb;

	class order_flag_board;
		logic [soqoc_pkg::DATA_W-1:0] fifo_mem [soqoc_pkg::DEPTH];
		logic [soqoc_pkg::DATA_W-1:0] stack_mem [soqoc_pkg::DEPTH];
		int rd_pos;
		int wr_pos;
		int held;
		bit fifo_ok;
		bit lifo_ok;
		bit err_seen;
		soqoc_pkg::res_item_t flags_due[$];
		int bad_flags;

		function new();
			bad_flags = 0;
			clear_trace();
		endfunction

		function void clear_trace();
			rd_pos = 0;
			wr_pos = 0;
			held = 0;
			fifo_ok = 1'b1;
			lifo_ok = 1'b1;
			err_seen = 1'b0;
		endfunction

		function int pending();
			return flags_due.size();
		endfunction

		// Update the order flags for one accepted item and queue the flags it must return.
		function void note_op(soqoc_pkg::cmd_item_t op);
			soqoc_pkg::res_item_t want;
			logic [soqoc_pkg::DATA_W-1:0] word;
			word = op.value;
			if (op.cmd == soqoc_pkg::CMD_PUSH) begin
				if (held >= soqoc_pkg::DEPTH) begin
					err_seen = 1'b1;
				end else begin
					fifo_mem[wr_pos] = word;
					wr_pos = (wr_pos == soqoc_pkg::DEPTH - 1) ? 0 : wr_pos + 1;
					stack_mem[held] = word;
					held++;
				end
			end else begin
				if (held == 0) begin
					fifo_ok = 1'b0;
					lifo_ok = 1'b0;
					err_seen = 1'b1;
				end else begin
					if (fifo_mem[rd_pos] != word)
						fifo_ok = 1'b0;
					rd_pos = (rd_pos == soqoc_pkg::DEPTH - 1) ? 0 : rd_pos + 1;
					held--;
					if (stack_mem[held] != word)
						lifo_ok = 1'b0;
				end
			end
			want.fifo_consistent = fifo_ok;
			want.lifo_consistent = lifo_ok;
			want.trace_error = err_seen;
			want.trace_done = op.last;
			flags_due.push_back(want);
			if (op.last)
				clear_trace();
		endfunction

		function void check_flags(soqoc_pkg::res_item_t got);
			soqoc_pkg::res_item_t want;
			if (flags_due.size() == 0) begin
				bad_flags++;
				if (bad_flags <= 10)
					$display("%0t: result with none expected: %p", $realtime, got);
				return;
			end
			want = flags_due.pop_front();
			if (want.fifo_consistent !== got.fifo_consistent ||
			    want.lifo_consistent !== got.lifo_consistent ||
			    want.trace_error !== got.trace_error ||
			    want.trace_done !== got.trace_done) begin
				bad_flags++;
				if (bad_flags <= 10)
					$display("%0t: flags mismatch fifo %b/%b lifo %b/%b err %b/%b done %b/%b",
						$realtime, want.fifo_consistent, got.fifo_consistent,
						want.lifo_consistent, got.lifo_consistent,
						want.trace_error, got.trace_error,
						want.trace_done, got.trace_done);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	soqoc_pkg::cmd_item_t cmd_item;
	logic res_valid;
	logic res_stall;
	soqoc_pkg::res_item_t res_item;

	order_flag_board board = new();
	bit steady = 1'b0;
	int rand_ops;

	stack_or_queue_order_checker_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_item(cmd_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item(res_item)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		res_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 22);
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			board.check_flags(res_item);
	end

	function automatic logic [soqoc_pkg::DATA_W-1:0] pick_word();
		case ($urandom_range(0, 19))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	// Hold the item until accepted, then maybe leave a gap.
	task automatic send_op(input logic op, input logic [soqoc_pkg::DATA_W-1:0] word,
		input logic fin);
		soqoc_pkg::cmd_item_t it;
		it.cmd = op;
		it.value = word;
		it.last = fin;
		cmd_valid <= 1'b1;
		cmd_item <= it;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		board.note_op(it);
		if (!steady && $urandom_range(0, 99) < 22) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		cmd_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One random trace: ordered pops in FIFO, LIFO or repeated-value style, or noise.
	task automatic random_trace();
		logic [soqoc_pkg::DATA_W-1:0] shadow[$];
		logic [soqoc_pkg::DATA_W-1:0] rep_word;
		logic [soqoc_pkg::DATA_W-1:0] word;
		int style;
		int len;
		logic op;
		style = $urandom_range(0, 3);
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
		rep_word = pick_word();
		for (int i = 0; i < len; i++) begin
			if (shadow.size() > 0)
				op = ($urandom_range(0, 99) < 45) ? soqoc_pkg::CMD_POP : soqoc_pkg::CMD_PUSH;
			else
				op = (style == 3 && $urandom_range(0, 1)) ? soqoc_pkg::CMD_POP
					: soqoc_pkg::CMD_PUSH;
			if (op == soqoc_pkg::CMD_PUSH) begin
				word = (style == 2) ? rep_word : pick_word();
				shadow.push_back(word);
			end else if (shadow.size() == 0) begin
				word = pick_word();
			end else begin
				case (style)
					0: word = shadow.pop_front();
					1: word = shadow.pop_back();
					2: word = shadow.pop_front();
					default: word = $urandom_range(0, 1) ? shadow.pop_front() : pick_word();
				endcase
				// break the order now and then
				if (style != 3 && $urandom_range(0, 49) == 0)
					word = word ^ (32'h1 << $urandom_range(0, 31));
			end
			send_op(op, word, i == len - 1);
			rand_ops++;
			steady = (rand_ops >= 300 && rand_ops < 450);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		cmd_item <= '0;
		rand_ops = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pop on empty, then a trace that can never recover
		send_op(soqoc_pkg::CMD_POP, 32'h0000_0000, 1'b0);
		send_op(soqoc_pkg::CMD_PUSH, 32'h7FFF_FFFF, 1'b0);
		send_op(soqoc_pkg::CMD_POP, 32'h7FFF_FFFF, 1'b1);
		// FIFO order holds, LIFO breaks
		send_op(soqoc_pkg::CMD_PUSH, 32'h8000_0000, 1'b0);
		send_op(soqoc_pkg::CMD_PUSH, 32'h0000_0000, 1'b0);
		send_op(soqoc_pkg::CMD_PUSH, 32'hFFFF_FFFF, 1'b0);
		send_op(soqoc_pkg::CMD_POP, 32'h8000_0000, 1'b0);
		send_op(soqoc_pkg::CMD_POP, 32'h0000_0000, 1'b0);
		send_op(soqoc_pkg::CMD_POP, 32'hFFFF_FFFF, 1'b1);
		// LIFO order holds, FIFO breaks
		send_op(soqoc_pkg::CMD_PUSH, 32'h0000_0001, 1'b0);
		send_op(soqoc_pkg::CMD_PUSH, 32'h0000_0002, 1'b0);
		send_op(soqoc_pkg::CMD_POP, 32'h0000_0002, 1'b0);
		send_op(soqoc_pkg::CMD_POP, 32'h0000_0001, 1'b1);
		// alternating bits, then pop past empty at the end of the trace
		send_op(soqoc_pkg::CMD_PUSH, 32'h5555_5555, 1'b0);
		send_op(soqoc_pkg::CMD_PUSH, 32'hAAAA_AAAA, 1'b0);
		send_op(soqoc_pkg::CMD_POP, 32'hAAAA_AAAA, 1'b0);
		send_op(soqoc_pkg::CMD_POP, 32'h5555_5555, 1'b0);
		send_op(soqoc_pkg::CMD_POP, 32'h0000_0000, 1'b1);
		// one-item traces, with entries left behind
		send_op(soqoc_pkg::CMD_PUSH, 32'hDEAD_BEEF, 1'b1);
		send_op(soqoc_pkg::CMD_POP, 32'hDEAD_BEEF, 1'b1);
		// clean trace after the leftovers
		send_op(soqoc_pkg::CMD_PUSH, 32'h0000_0003, 1'b0);
		send_op(soqoc_pkg::CMD_POP, 32'h0000_0003, 1'b1);

		drain_results();

		while (rand_ops < 730)
			random_trace();
		steady = 1'b0;

		drain_results();
		repeat (8) @(posedge clk);
		if (board.bad_flags == 0 && board.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#4ms;
		$display("simulation failed");
		$finish;
	end

endmodule

/* stack_or_queue_order_checker_top.f */
+incdir+rtl
rtl/soqoc_pkg.sv
rtl/soqoc_ram.sv
rtl/soqoc_ctrl.sv
rtl/stack_or_queue_order_checker_top.sv
sim/tb.sv
